// ----- sv/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg - animation frame selector shared definitions
// Item codes, playback codes, field widths and default sizes used by the
// frame selector and its port checker.
// ----------------------------------------------------------------------------
package afs_pkg;

    // default sizes of the delay table
    localparam int MAX_FRAMES_DEF = 64;
    localparam int DELAY_BITS_DEF = 16;

    // field widths of the stream items
    localparam int MODE_W      = 2;
    localparam int RAW_W       = 17;
    localparam int ELAPSED_W   = 32;
    localparam int PLAY_W      = 2;
    localparam int INDEX_W     = 6;
    localparam int TOTAL_W     = 7;
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    // delay substituted for a raw delay that is not positive
    localparam logic [15:0] DEFAULT_DELAY_MS = 16'd100;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // playback modes
    localparam logic [PLAY_W-1:0] PLAY_LOOP = 2'd0;
    localparam logic [PLAY_W-1:0] PLAY_HOLD = 2'd1;
    localparam logic [PLAY_W-1:0] PLAY_HIDE = 2'd2;

endpackage

// ----- sv/animation_frame_selector.sv -----
// ----------------------------------------------------------------------------
// animation_frame_selector - frame delay table with timeline lookup
// Stores per-frame delays in a synchronous memory and answers which frame
// is shown at a given elapsed time, with loop, hold and hide playback.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one item per transfer. s_tuser carries the item kind (clear,
//   append, query); s_tdata carries raw_delay, elapsed_ms and playback.
//   m_ channel: exactly one result per item, in order, in m_tdata.
//   Clear and append pass straight to the result state. A query does too
//   when the answer follows from the frame count and total alone,
//   otherwise it reads delays until the frame is found (at most
//   MAX_FRAMES reads), after a restoring remainder over the 32 elapsed
//   bits for loop playback.
//   The delay table has one registered read port; the walk
//   issues one read per cycle and accumulates the delays as they return.
//   One item is in work at a time; s_tready is high while the block waits
//   for an item, also while a finished result still sits in the output
//   register.
//   Reset empties the table (frame count and total duration go to zero);
//   the delay memory itself is not cleared. When m_tready is low the result
//   holds in the output register and the block waits before the next one.
// ----------------------------------------------------------------------------
module animation_frame_selector #(
    parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF,
    parameter int DELAY_BITS = afs_pkg::DELAY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // raw_delay[16:0], elapsed_ms[48:17], playback[50:49], zero fill
    input  logic [afs_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [afs_pkg::S_TUSER_W-1:0]  s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_index[5:0], visible[6], frame_total[13:7], table_full[14], zero fill
    output logic [afs_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int TOT_W = DELAY_BITS + $clog2(MAX_FRAMES);
    localparam int EW    = afs_pkg::ELAPSED_W;
    localparam int CMP_W = (TOT_W > EW) ? TOT_W : EW;
    localparam int DIV_W = $clog2(EW);
    localparam logic [31:0] DLY_MAX = 32'((64'd1 << DELAY_BITS) - 64'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    // input field unpacking
    logic [afs_pkg::MODE_W-1:0] in_mode;
    logic [afs_pkg::RAW_W-1:0]  in_raw;
    logic [EW-1:0]              in_elapsed;
    logic [afs_pkg::PLAY_W-1:0] in_play;

    assign in_mode    = s_tuser[1:0];
    assign in_raw     = s_tdata[16:0];
    assign in_elapsed = s_tdata[48:17];
    assign in_play    = s_tdata[50:49];

    // state and working registers
    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [EW-1:0]         elapsed_reg, elapsed_next;
    logic [TOT_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [TOT_W-1:0]      acc_reg, acc_next;
    logic [AW-1:0]         res_idx_reg, res_idx_next;
    logic                  res_vis_reg, res_vis_next;
    logic                  res_full_reg, res_full_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [afs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // delay memory
    logic [DELAY_BITS-1:0] delay_mem [MAX_FRAMES];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DELAY_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DELAY_BITS-1:0] mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            delay_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= delay_mem[mem_raddr];
        end
    end

    // append delay: default for non-positive, saturate to the stored width
    logic [15:0]  dly_raw;
    logic [31:0]  dly_sat;

    always_comb begin
        if (in_raw[16] || (in_raw == '0)) begin
            dly_raw = afs_pkg::DEFAULT_DELAY_MS;
        end else begin
            dly_raw = in_raw[15:0];
        end
        if (32'(dly_raw) > DLY_MAX) begin
            dly_sat = DLY_MAX;
        end else begin
            dly_sat = 32'(dly_raw);
        end
    end

    // restoring remainder step
    logic [TOT_W:0]   div_shift;
    logic [TOT_W:0]   div_total;
    logic [TOT_W-1:0] div_rem;

    assign div_shift = {rem_reg, elapsed_reg[EW-1]};
    assign div_total = {1'b0, total_reg};

    always_comb begin
        if (div_shift >= div_total) begin
            div_rem = TOT_W'(div_shift - div_total);
        end else begin
            div_rem = TOT_W'(div_shift);
        end
    end

    // walk accumulation
    logic [TOT_W-1:0] acc_sum;
    logic             walk_hit;
    logic             walk_last;
    logic [AW-1:0]    last_idx;

    assign acc_sum   = acc_reg + TOT_W'(mem_rdata_reg);
    assign walk_hit  = CMP_W'(elapsed_reg) < CMP_W'(acc_sum);
    assign last_idx  = AW'(count_reg - CNT_W'(1));
    assign walk_last = (rd_idx_reg == last_idx);

    assign s_tready = (state_reg == ST_IDLE);

    // control and datapath next state
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        elapsed_next  = elapsed_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        acc_next      = acc_reg;
        res_idx_next  = res_idx_reg;
        res_vis_next  = res_vis_reg;
        res_full_next = res_full_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = DELAY_BITS'(dly_sat);
        mem_re        = 1'b0;
        mem_raddr     = rd_cnt_reg[AW-1:0];

        // output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_idx_next  = '0;
                    res_vis_next  = 1'b0;
                    res_full_next = 1'b0;
                    elapsed_next  = in_elapsed;
                    rem_next      = '0;
                    div_cnt_next  = '0;
                    rd_cnt_next   = '0;
                    acc_next      = '0;
                    state_next    = ST_FIN;
                    case (in_mode)
                        afs_pkg::MODE_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                        end
                        afs_pkg::MODE_APPEND: begin
                            if (count_reg >= CNT_W'(MAX_FRAMES)) begin
                                res_full_next = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                total_next = total_reg + TOT_W'(dly_sat);
                            end
                        end
                        afs_pkg::MODE_QUERY: begin
                            if (count_reg != '0) begin
                                res_vis_next = 1'b1;
                                if (total_reg == '0) begin
                                    state_next = ST_FIN;
                                end else if (in_play == afs_pkg::PLAY_LOOP) begin
                                    state_next = ST_DIV;
                                end else if (CMP_W'(in_elapsed) >= CMP_W'(total_reg)) begin
                                    if (in_play == afs_pkg::PLAY_HOLD) begin
                                        res_idx_next = last_idx;
                                    end else begin
                                        res_vis_next = 1'b0;
                                    end
                                end else begin
                                    state_next = ST_WALK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one remainder bit per cycle, dividend shifts out of elapsed
            ST_DIV: begin
                rem_next     = div_rem;
                elapsed_next = elapsed_reg << 1;
                div_cnt_next = div_cnt_reg + DIV_W'(1);
                if (div_cnt_reg == DIV_W'(EW - 1)) begin
                    elapsed_next = EW'(div_rem);
                    state_next   = ST_WALK;
                end
            end

            // one read issued per cycle, delays summed as they return
            ST_WALK: begin
                if (rd_cnt_reg < count_reg) begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_cnt_reg[AW-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    acc_next = acc_sum;
                    if (walk_hit) begin
                        res_idx_next = rd_idx_reg;
                        rd_vld_next  = 1'b0;
                        state_next   = ST_FIN;
                    end else if (walk_last) begin
                        res_idx_next = last_idx;
                        rd_vld_next  = 1'b0;
                        state_next   = ST_FIN;
                    end
                end
            end

            // hand the result to the output register once it is free
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[5:0]  = afs_pkg::INDEX_W'(res_idx_reg);
                    m_tdata_next[6]    = res_vis_reg;
                    m_tdata_next[13:7] = afs_pkg::TOTAL_W'(count_reg);
                    m_tdata_next[14]   = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        elapsed_reg  <= elapsed_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        rd_cnt_reg   <= rd_cnt_next;
        rd_idx_reg   <= rd_idx_next;
        acc_reg      <= acc_next;
        res_idx_reg  <= res_idx_next;
        res_vis_reg  <= res_vis_next;
        res_full_reg <= res_full_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/afs_checker.sv -----
// ----------------------------------------------------------------------------
// afs_checker - port checker for the animation frame selector
// Watches the result channel for stall behavior and consistency of the
// result fields.
// ----------------------------------------------------------------------------
module afs_checker #(
    parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [afs_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a refused append shows no frame
    a_full_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> (m_tdata[6:0] == 7'd0))
        else $error("full flag with frame selected");

    // frame count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MAX_FRAMES > 127) || (m_tdata[13:7] <= 7'(MAX_FRAMES)))
        else $error("frame total beyond table size");

    // a visible frame lies inside the table
    a_vis_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> (MAX_FRAMES > 64) ||
            ({1'b0, m_tdata[5:0]} < m_tdata[13:7]))
        else $error("visible frame beyond frame total");

endmodule

bind animation_frame_selector afs_checker #(
    .MAX_FRAMES (MAX_FRAMES)
) u_afs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the animation frame selector
// Streams clear, append, query and unused-kind items into the block and checks every
// result against a shadow frame table kept in the bench.
// ----------------------------------------------------------------------------
module tb;

    // codes the package leaves unnamed
    localparam logic [afs_pkg::MODE_W-1:0] MODE_RSVD = 2'd3;
    localparam logic [afs_pkg::PLAY_W-1:0] PLAY_RSVD = 2'd3;

    localparam int SHADOW_FRAMES = afs_pkg::MAX_FRAMES_DEF;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CALM_TAIL     = 80;
    localparam int DRAIN_CYCLES  = 150;
    localparam int HOLD_OFF_LEN  = 300;

    typedef struct {
        logic [afs_pkg::MODE_W-1:0]    mode;
        logic [afs_pkg::RAW_W-1:0]     raw_delay;
        logic [afs_pkg::ELAPSED_W-1:0] elapsed_ms;
        logic [afs_pkg::PLAY_W-1:0]    playback;
    } anim_item_t;

    typedef struct packed {
        logic                        table_full;
        logic [afs_pkg::TOTAL_W-1:0] frame_total;
        logic                        visible;
        logic [afs_pkg::INDEX_W-1:0] frame_index;
    } frame_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // raw_delay[16:0], elapsed_ms[48:17], playback[50:49], zero fill
    logic [afs_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // mode[1:0]
    logic [afs_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // frame_index[5:0], visible[6], frame_total[13:7], table_full[14], zero fill
    logic [afs_pkg::M_TDATA_W-1:0] m_tdata;

    anim_item_t    pending_items[$];
    frame_result_t expected_frames[$];

    // shadow copy of the frame table
    logic [15:0] shadow_delays [SHADOW_FRAMES];
    logic [6:0]  shadow_count = '0;
    logic [21:0] shadow_total = '0;

    int          mismatches = 0;
    int          items_sent = 0;
    int          calm_mark = 0;
    int          results_seen = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;
    bit          hold_off_done = 1'b0;
    anim_item_t  cur_item;

    // generator side view of the table, used to aim query times and to count items
    int unsigned gen_total = 0;
    int          gen_items = 0;

    animation_frame_selector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // timeout
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // apply one item to the shadow table and return the expected result
    function automatic frame_result_t advance_timeline(anim_item_t it);
        frame_result_t res;
        logic [15:0]   dly;
        logic [31:0]   t;
        logic [31:0]   acc;
        bit            found;
        res = '0;
        case (it.mode)
            afs_pkg::MODE_CLEAR: begin
                shadow_count = '0;
                shadow_total = '0;
            end
            afs_pkg::MODE_APPEND: begin
                if (shadow_count >= SHADOW_FRAMES) begin
                    res.table_full = 1'b1;
                end else begin
                    // positive raw delays top out at 65535 and always fit
                    if (it.raw_delay[afs_pkg::RAW_W-1] || it.raw_delay == '0)
                        dly = afs_pkg::DEFAULT_DELAY_MS;
                    else
                        dly = it.raw_delay[15:0];
                    shadow_delays[shadow_count[5:0]] = dly;
                    shadow_count = shadow_count + 7'd1;
                    shadow_total = shadow_total + 22'(dly);
                end
            end
            afs_pkg::MODE_QUERY: begin
                if (shadow_count != 0) begin
                    res.visible = 1'b1;
                    t = it.elapsed_ms;
                    found = 1'b0;
                    if (shadow_total == 0) begin
                        found = 1'b1;
                    end else if (it.playback == afs_pkg::PLAY_LOOP) begin
                        t = it.elapsed_ms % {10'd0, shadow_total};
                    end else if (it.playback == afs_pkg::PLAY_HOLD) begin
                        if (t >= {10'd0, shadow_total}) begin
                            res.frame_index = afs_pkg::INDEX_W'(shadow_count - 7'd1);
                            found = 1'b1;
                        end
                    end else if (t >= {10'd0, shadow_total}) begin
                        // hide after end, also for the unused playback code
                        res.visible = 1'b0;
                        found = 1'b1;
                    end
                    // walk the cumulative delays
                    acc = '0;
                    for (int i = 0; i < SHADOW_FRAMES; i++) begin
                        if (!found && i < shadow_count) begin
                            acc = acc + {16'd0, shadow_delays[i]};
                            if (t < acc) begin
                                res.frame_index = afs_pkg::INDEX_W'(i);
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found)
                        res.frame_index = afs_pkg::INDEX_W'(shadow_count - 7'd1);
                end
            end
            default: ;
        endcase
        res.frame_total = shadow_count;
        return res;
    endfunction

    task automatic push_item(logic [afs_pkg::MODE_W-1:0] mode,
                             logic [afs_pkg::RAW_W-1:0] raw,
                             logic [afs_pkg::ELAPSED_W-1:0] elapsed,
                             logic [afs_pkg::PLAY_W-1:0] play);
        anim_item_t it;
        it.mode       = mode;
        it.raw_delay  = raw;
        it.elapsed_ms = elapsed;
        it.playback   = play;
        pending_items.insert(pending_items.size(), it);
        if (mode != MODE_RSVD)
            gen_items++;
        if (mode == afs_pkg::MODE_CLEAR)
            gen_total = 0;
        else if (mode == afs_pkg::MODE_APPEND)
            gen_total += (raw[afs_pkg::RAW_W-1] || raw == '0) ? 100 : int'(raw);
    endtask

    // mostly short delays so that query times land across many frames
    function automatic logic [afs_pkg::RAW_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {1'b1, 16'($urandom)};
            2:       return afs_pkg::RAW_W'($urandom);
            default: return afs_pkg::RAW_W'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic logic [afs_pkg::PLAY_W-1:0] pick_playback();
        if ($urandom_range(0, 15) == 0)
            return PLAY_RSVD;
        return afs_pkg::PLAY_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [afs_pkg::ELAPSED_W-1:0] pick_elapsed();
        longint span;
        if (gen_total == 0)
            return $urandom;
        span = longint'(gen_total);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: return $urandom_range(0, gen_total - 1);
            8, 9, 10, 11:           return gen_total + $urandom_range(0, 2) - 1;
            12, 13, 14:             return $urandom;
            15, 16, 17:             return $urandom_range(gen_total, 3 * gen_total);
            default:                return afs_pkg::ELAPSED_W'(
                                        span * $urandom_range(2, 500)
                                        + $urandom_range(0, 3));
        endcase
    endfunction

    task automatic push_query();
        push_item(afs_pkg::MODE_QUERY, afs_pkg::RAW_W'($urandom), pick_elapsed(),
                  pick_playback());
    endtask

    task automatic push_noise();
        push_item(MODE_RSVD, afs_pkg::RAW_W'($urandom), $urandom,
                  afs_pkg::PLAY_W'($urandom));
    endtask

    task automatic fill_directed();
        // queries on the empty table
        push_item(afs_pkg::MODE_QUERY, '0, '0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_QUERY, '1, '1, afs_pkg::PLAY_HOLD);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd5, afs_pkg::PLAY_HIDE);
        // zero, negative, largest and smallest delays: 100+100+100+65535+1
        push_item(afs_pkg::MODE_APPEND, 17'd0, '0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_APPEND, 17'h1FFFF, '0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_APPEND, 17'h10000, '1, PLAY_RSVD);
        push_item(afs_pkg::MODE_APPEND, 17'h0FFFF, '0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_APPEND, 17'd1, '0, afs_pkg::PLAY_LOOP);
        // loop playback at the start, just before the end, at the end, wrapped
        push_item(afs_pkg::MODE_QUERY, '0, 32'd0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd65835, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd65836, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_QUERY, '1, 32'hFFFF_FFFF, afs_pkg::PLAY_LOOP);
        // hold last frame past the end, and one hold query inside the timeline
        push_item(afs_pkg::MODE_QUERY, '0, 32'd65836, afs_pkg::PLAY_HOLD);
        push_item(afs_pkg::MODE_QUERY, '0, 32'hFFFF_FFFF, afs_pkg::PLAY_HOLD);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd99, afs_pkg::PLAY_HOLD);
        // hide after end, and the unused playback code
        push_item(afs_pkg::MODE_QUERY, '0, 32'd65836, afs_pkg::PLAY_HIDE);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd65835, afs_pkg::PLAY_HIDE);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd65836, PLAY_RSVD);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd100, PLAY_RSVD);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd300, afs_pkg::PLAY_LOOP);
        // unused item kind
        push_item(MODE_RSVD, '1, '1, '1);
        // clear, then a one-frame table
        push_item(afs_pkg::MODE_CLEAR, '1, '1, '1);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_APPEND, 17'd2, '0, afs_pkg::PLAY_LOOP);
        push_item(afs_pkg::MODE_QUERY, '0, 32'd1, afs_pkg::PLAY_HIDE);
    endtask

    task automatic fill_random();
        int n_app;
        int n_qry;
        int target;
        target = gen_items + RANDOM_ITEMS;
        while (gen_items < target) begin
            if ($urandom_range(0, 5) != 0) begin
                push_item(afs_pkg::MODE_CLEAR, afs_pkg::RAW_W'($urandom), $urandom,
                          afs_pkg::PLAY_W'($urandom));
                if ($urandom_range(0, 7) == 0)
                    push_query();
            end
            // mostly short tables, now and then one that overflows
            case ($urandom_range(0, 9))
                0:       n_app = $urandom_range(60, 70);
                1, 2:    n_app = $urandom_range(9, 40);
                default: n_app = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < n_app; i++) begin
                push_item(afs_pkg::MODE_APPEND, pick_delay(), $urandom,
                          afs_pkg::PLAY_W'($urandom));
                if ($urandom_range(0, 5) == 0)
                    push_query();
                if ($urandom_range(0, 19) == 0)
                    push_noise();
            end
            n_qry = $urandom_range(3, 10);
            for (int i = 0; i < n_qry; i++) begin
                push_query();
                if ($urandom_range(0, 19) == 0)
                    push_noise();
            end
        end
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // input driver: offers queued items, with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_frames.insert(expected_frames.size(), advance_timeline(cur_item));
                items_sent++;
                if (items_sent >= calm_mark)
                    calm = 1'b1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.mode;
                    s_tdata  <= {5'd0, cur_item.playback, cur_item.elapsed_ms,
                                 cur_item.raw_delay};
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each transfer, stalls at random
    always @(posedge aclk) begin
        frame_result_t exp_r;
        frame_result_t act_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                act_r = m_tdata[14:0];
                results_seen++;
                if (expected_frames.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $realtime, m_tdata);
                    mismatches++;
                end else begin
                    exp_r = expected_frames.pop_front();
                    check_field("frame_index", exp_r.frame_index, act_r.frame_index);
                    check_field("visible", exp_r.visible, act_r.visible);
                    check_field("frame_total", exp_r.frame_total, act_r.frame_total);
                    check_field("table_full", exp_r.table_full, act_r.table_full);
                end
            end
            // one long hold-off so the block backs up onto its input
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!hold_off_done && results_seen >= 100) begin
                hold_off_done = 1'b1;
                stall_left = HOLD_OFF_LEN - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        for (int i = 0; i < SHADOW_FRAMES; i++)
            shadow_delays[i] = '0;
        fill_directed();
        fill_random();
        calm_mark = pending_items.size() - CALM_TAIL;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_items.size() != 0 || s_tvalid || expected_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_frames.size() != 0) begin
            $display("%0t missing results: expected %0d more actual 0",
                     $realtime, expected_frames.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/afs_pkg.sv
sv/animation_frame_selector.sv
sv/afs_checker.sv
tb/sv/tb.sv
